// ----- src/csmg_pkg.sv -----
// Shared types and codes for the cosine similarity memory gradient block.
// No dependencies.
package csmg_pkg;

  localparam logic [1:0] MODE_KEY  = 2'd0;
  localparam logic [1:0] MODE_SLOT = 2'd1;
  localparam logic [1:0] MODE_GRAD = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         controller_index;
    logic [5:0]         slot_index;
    logic [5:0]         element_index;
    logic signed [15:0] element_value;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]         out_element;
    logic signed [31:0] gradient;
    logic               zero_norm;
    logic               last;
  } out_beat_t;

endpackage

// ----- src/csmg_store.sv -----
// Single-port-write, single-port-read element store with registered read data.
// Uses no package items.
module csmg_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- src/cosine_similarity_memory_gradient.sv -----
// Top level: key and slot stores, sequencer and shared shift-add / sqrt / divide datapath.
// Depends on csmg_pkg and csmg_store.
//
// Usage: the in channel (in_valid/in_ready/in_beat) takes one beat per request. A key or
// slot load gives no result. A gradient request gives L = min(vec_len, MAX_VEC_LEN) beats
// on the out channel (out_valid/out_ready/out_beat), in element order, last set on the
// final one; vec_len 0 gives none. in_ready is high only while the sequencer is idle.
// The shared unit is bit-serial: one multiplier bit, one root bit or one quotient bit per
// cycle, 33 quotient bits per element unless the quotient overflows and saturates.
// A zero norm skips the arithmetic and gives zero_norm beats with a zero gradient.
// The cfg channel (cfg_valid/cfg_ready/cfg_data) writes vec_len; cfg_ready is always high.
// Reset sets vec_len to 64, empties the output register and idles the sequencer; the
// stores are not cleared. A stalled receiver holds the output register and the sequencer
// waits with the next result until the beat is taken.
module cosine_similarity_memory_gradient
  import csmg_pkg::*;
#(
  parameter int MAX_VEC_LEN     = 64,
  parameter int NUM_SLOTS       = 64,
  parameter int NUM_CONTROLLERS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_beat,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [6:0] cfg_data
);

  localparam int CL    = $clog2(MAX_VEC_LEN + 1);
  localparam int SKW   = 31 + CL;
  localparam int DW    = SKW + 1;
  localparam int PW    = 2 * SKW;
  localparam int RW    = SKW + 16;
  localparam int DENW  = RW + SKW;
  localparam int MW    = 16 + DW;
  localparam int NW    = MW + 1;
  localparam int REMW  = DENW + 1;
  localparam int QW    = 33;
  localparam int KD    = NUM_CONTROLLERS * MAX_VEC_LEN;
  localparam int SD    = NUM_SLOTS * MAX_VEC_LEN;
  localparam int KAW   = (KD > 1) ? $clog2(KD) : 1;
  localparam int SAW   = (SD > 1) ? $clog2(SD) : 1;
  localparam int KRW   = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;
  localparam int SRW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_PMUL, S_SQRT, S_DMUL, S_RD, S_NK, S_NM, S_DV0, S_DIV, S_SAT, S_EMIT
  } state_t;

  state_t state_r;
  logic [6:0] vec_len_r, len_r, cnt_r;
  logic rv_r, zero_r, neg_r, ovf_r;
  logic [KAW-1:0] kbase_r;
  logic [SAW-1:0] sbase_r;
  logic [SKW-1:0] sk_r, sm_r;
  logic signed [DW-1:0] d_r;
  logic [DENW-1:0] acc_r, den_r;
  logic [RW-1:0] mul_a_r, root_r;
  logic [SKW-1:0] mul_b_r;
  logic [2*RW-1:0] e_r;
  logic [RW+1:0] srem_r;
  logic [7:0] it_r;
  logic signed [MW-1:0] nk_r;
  logic [NW-1:0] mag_r;
  logic [REMW-1:0] rem_r;
  logic [QW-1:0] q_r;
  logic signed [31:0] g_r;
  logic out_valid_r;
  out_beat_t out_beat_r;

  logic [KRW-1:0] ctl_wrap [16];
  logic [SRW-1:0] slot_wrap [64];

  for (genvar g = 0; g < 16; g++) begin : g_ctl
    assign ctl_wrap[g] = KRW'(g % NUM_CONTROLLERS);
  end
  for (genvar g = 0; g < 64; g++) begin : g_slot
    assign slot_wrap[g] = SRW'(g % NUM_SLOTS);
  end

  logic [KAW-1:0] in_kbase, k_waddr, k_raddr;
  logic [SAW-1:0] in_sbase, s_waddr, s_raddr;
  logic elem_ok, in_acc, k_we, s_we;
  logic [15:0] k_rd, s_rd;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign in_kbase  = KAW'(KAW'(ctl_wrap[in_beat.controller_index]) * KAW'(MAX_VEC_LEN));
  assign in_sbase  = SAW'(SAW'(slot_wrap[in_beat.slot_index]) * SAW'(MAX_VEC_LEN));
  assign elem_ok   = 9'(in_beat.element_index) < 9'(MAX_VEC_LEN);
  assign k_we      = in_acc && in_beat.mode == MODE_KEY && elem_ok;
  assign s_we      = in_acc && in_beat.mode == MODE_SLOT && elem_ok;
  assign k_waddr   = KAW'(in_kbase + KAW'(in_beat.element_index));
  assign s_waddr   = SAW'(in_sbase + SAW'(in_beat.element_index));
  assign k_raddr   = KAW'(kbase_r + KAW'(cnt_r));
  assign s_raddr   = SAW'(sbase_r + SAW'(cnt_r));

  csmg_store #(.DEPTH(KD), .AW(KAW)) u_key (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(in_beat.element_value),
    .raddr(k_raddr), .rdata(k_rd)
  );

  csmg_store #(.DEPTH(SD), .AW(SAW)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(in_beat.element_value),
    .raddr(s_raddr), .rdata(s_rd)
  );

  logic signed [31:0] pkk, pmm, pkm;
  assign pkk = $signed(k_rd) * $signed(k_rd);
  assign pmm = $signed(s_rd) * $signed(s_rd);
  assign pkm = $signed(k_rd) * $signed(s_rd);

  logic [DENW-1:0] acc_step;
  assign acc_step = DENW'(acc_r << 1) + (mul_b_r[SKW-1] ? DENW'(mul_a_r) : '0);

  logic [RW+1:0] srem_sh, strial;
  assign srem_sh = (RW+2)'({srem_r[RW-1:0], e_r[2*RW-1 -: 2]});
  assign strial  = (RW+2)'({root_r, 2'b01});

  logic signed [15:0] mx;
  logic signed [DW-1:0] my;
  logic signed [MW-1:0] mprod;
  logic signed [NW-1:0] n_val;
  assign mx    = (state_r == S_NK) ? $signed(k_rd) : $signed(s_rd);
  assign my    = (state_r == S_NK) ? $signed({1'b0, sm_r}) : d_r;
  assign mprod = MW'(mx) * MW'(my);
  assign n_val = NW'(nk_r) - NW'(mprod);

  logic [REMW-1:0] rem_init, rem_sh;
  assign rem_init = REMW'(mag_r) << 18;
  assign rem_sh   = REMW'(rem_r << 1);

  logic [6:0] len_in;
  assign len_in = (8'(vec_len_r) > 8'(MAX_VEC_LEN)) ? 7'(MAX_VEC_LEN) : vec_len_r;

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vec_len_r   <= 7'd64;
      out_valid_r <= 1'b0;
      rv_r        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        vec_len_r <= cfg_data;
      end
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_beat.mode == MODE_GRAD && len_in != 7'd0) begin
            kbase_r <= in_kbase;
            sbase_r <= in_sbase;
            len_r   <= len_in;
            cnt_r   <= '0;
            rv_r    <= 1'b0;
            sk_r    <= '0;
            sm_r    <= '0;
            d_r     <= '0;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          rv_r <= (cnt_r < len_r);
          if (cnt_r < len_r) begin
            cnt_r <= cnt_r + 7'd1;
          end
          if (rv_r) begin
            sk_r <= sk_r + SKW'(pkk[30:0]);
            sm_r <= sm_r + SKW'(pmm[30:0]);
            d_r  <= d_r + DW'(pkm);
          end
          if (cnt_r == len_r && !rv_r) begin
            zero_r <= (sk_r == '0) || (sm_r == '0);
            cnt_r  <= '0;
            if (sk_r == '0 || sm_r == '0) begin
              state_r <= S_RD;
            end else begin
              mul_a_r <= RW'(sk_r);
              mul_b_r <= sm_r;
              acc_r   <= '0;
              it_r    <= 8'(SKW);
              state_r <= S_PMUL;
            end
          end
        end
        S_PMUL: begin
          acc_r   <= acc_step;
          mul_b_r <= mul_b_r << 1;
          if (it_r == 8'd1) begin
            e_r     <= {acc_step[PW-1:0], 32'd0};
            srem_r  <= '0;
            root_r  <= '0;
            it_r    <= 8'(RW);
            state_r <= S_SQRT;
          end else begin
            it_r <= it_r - 8'd1;
          end
        end
        S_SQRT: begin
          e_r  <= e_r << 2;
          it_r <= it_r - 8'd1;
          if (srem_sh >= strial) begin
            srem_r <= srem_sh - strial;
            root_r <= {root_r[RW-2:0], 1'b1};
          end else begin
            srem_r <= srem_sh;
            root_r <= {root_r[RW-2:0], 1'b0};
          end
          if (it_r == 8'd1) begin
            state_r <= S_DMUL;
          end
        end
        S_DMUL: begin
          if (it_r == 8'd0) begin
            mul_a_r <= root_r;
            mul_b_r <= sm_r;
            acc_r   <= '0;
            it_r    <= 8'(SKW);
          end else begin
            acc_r   <= acc_step;
            mul_b_r <= mul_b_r << 1;
            it_r    <= it_r - 8'd1;
            if (it_r == 8'd1) begin
              den_r   <= acc_step;
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          if (zero_r) begin
            g_r     <= '0;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_NK;
          end
        end
        S_NK: begin
          nk_r    <= mprod;
          state_r <= S_NM;
        end
        S_NM: begin
          neg_r   <= n_val[NW-1];
          mag_r   <= n_val[NW-1] ? NW'(-n_val) : NW'(n_val);
          state_r <= S_DV0;
        end
        S_DV0: begin
          rem_r   <= rem_init;
          ovf_r   <= (rem_init >= REMW'(den_r));
          q_r     <= '0;
          it_r    <= 8'(QW);
          state_r <= (rem_init >= REMW'(den_r)) ? S_SAT : S_DIV;
        end
        S_DIV: begin
          it_r <= it_r - 8'd1;
          if (rem_sh >= REMW'(den_r)) begin
            rem_r <= rem_sh - REMW'(den_r);
            q_r   <= {q_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            q_r   <= {q_r[QW-2:0], 1'b0};
          end
          if (it_r == 8'd1) begin
            state_r <= S_SAT;
          end
        end
        S_SAT: begin
          if (neg_r) begin
            g_r <= (ovf_r || q_r > 33'h080000000) ? 32'sh80000000 : $signed(-q_r[31:0]);
          end else begin
            g_r <= (ovf_r || q_r > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(q_r[31:0]);
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r            <= 1'b1;
            out_beat_r.out_element <= cnt_r[5:0];
            out_beat_r.gradient    <= g_r;
            out_beat_r.zero_norm   <= zero_r;
            out_beat_r.last        <= (cnt_r + 7'd1 == len_r);
            if (cnt_r + 7'd1 == len_r) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r   <= cnt_r + 7'd1;
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule
